@@ rtl/upb_pkg.sv @@
// Types and constants shared by the UDP port binding table modules.
// Holds command and status codes, the table entry layout and the
// controller/datapath handshake structs. No dependencies.
package upb_pkg;

   // Command codes carried in the request tuser field
   localparam logic [1:0] CMD_BIND   = 2'd0;
   localparam logic [1:0] CMD_UNBIND = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BOUND  = 2'd1;
   localparam logic [1:0] ST_NOPORT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // Field widths
   localparam int PORT_W   = 16;
   localparam int DOMAIN_W = 32;
   localparam int CORE_W   = 8;

   // One stored binding
   typedef struct packed {
      logic [CORE_W-1:0]   core;
      logic [DOMAIN_W-1:0] domain;
      logic [PORT_W-1:0]   port;
   } upb_entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic start;   // capture request, restart the scan
      logic scan;    // read the entry at the scan index, advance it
      logic commit;  // update the table and load the response register
   } upb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_last; // scan index sits on the last entry
      logic out_free;  // response register can take a new transfer
   } upb_stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } upb_state_type;

endpackage

@@ rtl/upb_ctrl.sv @@
// Sequencer for the UDP port binding table.
// Depends on upb_pkg; drives upb_datapath through command/status structs.
module upb_ctrl
   import upb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  upb_stat_type stat,
   output upb_cmd_type  cmd
);

   upb_state_type state_ff;
   upb_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         // last read entry is evaluated here
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/upb_datapath.sv @@
// Datapath of the UDP port binding table: entry memory, valid bits,
// scan match/free tracking and the response register. Depends on upb_pkg.
module upb_datapath
   import upb_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  upb_cmd_type         cmd,
   output upb_stat_type        stat,
   input  logic [1:0]          req_op,
   input  logic [PORT_W-1:0]   req_port,
   input  logic [DOMAIN_W-1:0] req_domain,
   input  logic [CORE_W-1:0]   req_core,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [DOMAIN_W-1:0] rsp_domain,
   output logic [CORE_W-1:0]   rsp_core
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   // Captured request
   logic [1:0]          op_ff;
   logic [PORT_W-1:0]   port_ff;
   logic [DOMAIN_W-1:0] dom_ff;
   logic [CORE_W-1:0]   core_ff;

   // Table storage
   upb_entry_type             mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]  valid_ff;

   // Scan pipeline
   logic [IW-1:0]  scan_idx_ff;
   upb_entry_type  rd_word_ff;
   logic [IW-1:0]  rd_idx_ff;
   logic           rd_live_ff;

   // Search results
   logic                hit_ff;
   logic [IW-1:0]       hit_idx_ff;
   logic [DOMAIN_W-1:0] hit_dom_ff;
   logic [CORE_W-1:0]   hit_core_ff;
   logic                free_ff;
   logic [IW-1:0]       free_idx_ff;

   // Response register
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [DOMAIN_W-1:0] rsp_dom_ff;
   logic [CORE_W-1:0]   rsp_core_ff;

   logic                ent_match;
   logic                ent_free;
   logic                do_write;
   logic                do_clear;
   logic [1:0]          status_in;
   logic [DOMAIN_W-1:0] dom_in;
   logic [CORE_W-1:0]   core_in;

   // Capture the request on start
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_op;
         port_ff <= req_port;
         dom_ff  <= req_domain;
         core_ff <= req_core;
      end
   end

   // Advance the scan index and read one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan;
         if (cmd.start) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff <= mem[scan_idx_ff];
      rd_idx_ff  <= scan_idx_ff;
   end

   // Evaluate the entry that came back from memory
   assign ent_match = rd_live_ff && valid_ff[rd_idx_ff] && (rd_word_ff.port == port_ff);
   assign ent_free  = rd_live_ff && !valid_ff[rd_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (ent_match) begin
            hit_ff <= 1'b1;
         end
         // keep the lowest free slot
         if (ent_free && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_match) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_dom_ff  <= rd_word_ff.domain;
         hit_core_ff <= rd_word_ff.core;
      end
      if (ent_free && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // Resolve the command outcome
   always_comb begin
      do_write  = 1'b0;
      do_clear  = 1'b0;
      status_in = ST_NOPORT;
      dom_in    = '0;
      core_in   = '0;
      case (op_ff)
         CMD_BIND: begin
            if (hit_ff) begin
               status_in = ST_BOUND;
            end else if (!free_ff) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
               do_write  = 1'b1;
            end
         end
         CMD_UNBIND: begin
            if (hit_ff) begin
               status_in = ST_OK;
               do_clear  = 1'b1;
            end
         end
         // lookup, and the unused code treated as one
         default: begin
            if (hit_ff) begin
               status_in = ST_OK;
               dom_in    = hit_dom_ff;
               core_in   = hit_core_ff;
            end
         end
      endcase
   end

   // Write the new binding into the lowest free slot
   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) begin
         mem[free_idx_ff] <= '{core: core_ff, domain: dom_ff, port: port_ff};
      end
   end

   // Set or drop valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         if (do_write) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (do_clear) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end
      end
   end

   // Hold the response until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_dom_ff    <= dom_in;
         rsp_core_ff   <= core_in;
      end
   end

   assign stat.scan_last = (scan_idx_ff == LAST_IDX);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_domain = rsp_dom_ff;
   assign rsp_core   = rsp_core_ff;

`ifndef SYNTHESIS
   // a commit never overwrites a response that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transfer");

   // owner fields are zero on every non-ok response
   a_owner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_dom_ff == '0 && rsp_core_ff == '0))
      else $error("owner fields set on failed command");

   // a successful bind adds exactly one valid entry
   a_bind_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_write) |=>
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("bind did not add one entry");

   // a successful unbind removes exactly one valid entry
   a_unbind_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_clear) |=>
         ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("unbind did not remove one entry");
`endif

endmodule

@@ rtl/udp_port_binding_table.sv @@
// UDP port binding table: bind, unbind and look up the owner of UDP ports.
// Top level; instantiates upb_ctrl and upb_datapath, depends on upb_pkg.
//
// Usage:
//   Request channel req_*: one command per transfer; tuser carries the
//   command (bind, unbind, lookup), tdata the port, domain and core.
//   Response channel rsp_*: one result per request, in request order,
//   carrying the status and, for a successful lookup, the owner.
// Timing:
//   Each request scans the whole table through the single read port of the
//   entry memory, one entry per cycle. An accepted request steps through the
//   scan, drain and commit states; commit, which waits for a free response
//   register, loads it, and the next request is taken back in idle.
// Reset:
//   Synchronous, active high. All valid bits clear at once, so the table is
//   empty right after reset; the memory needs no clearing pass.
// Stall:
//   The response sits in an output register; a new request is accepted and
//   scanned while it waits. The table update and the next response wait
//   until the pending response has been transferred.
module udp_port_binding_table
   import upb_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // port_number[15:0], domain_id[47:16], core_id[55:48]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // status[1:0], owner_domain[33:2], owner_core[41:34], zero
);

   upb_cmd_type         cmd;
   upb_stat_type        stat;
   logic [1:0]          rsp_status;
   logic [DOMAIN_W-1:0] rsp_domain;
   logic [CORE_W-1:0]   rsp_core;

   upb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   upb_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_port   (req_tdata[15:0]),
      .req_domain (req_tdata[47:16]),
      .req_core   (req_tdata[55:48]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_domain (rsp_domain),
      .rsp_core   (rsp_core)
   );

   // Pack the response word
   assign rsp_tdata = {6'd0, rsp_core, rsp_domain, rsp_status};

endmodule
